[rtl/core/pwl_pkg.sv]
// pwl_pkg: shared types and codes for the process wait list
// status codes, controller states and the result record passed to the output stage
// no dependencies
package pwl_pkg;

	localparam int ID_W    = 6;
	localparam int CODE_W  = 32;
	localparam int ENTRY_W = 2 * ID_W;

	typedef enum logic {
		CMD_WAIT = 1'b0,
		CMD_WAKE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_WOKEN      = 2'd0,
		STAT_REGISTERED = 2'd1,
		STAT_FULL       = 2'd2,
		STAT_NONE       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK
	} state_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   woken_id;
		logic [CODE_W-1:0] code_out;
		logic              last;
	} result_t;

	typedef struct packed {
		logic    push;
		result_t res;
	} push_t;

endpackage

[rtl/core/pwl_mem.sv]
// pwl_mem: wait entry storage, one write port and two registered read ports
// entry layout {waiter, target}; uses pwl_pkg for the entry width
module pwl_mem import pwl_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [ENTRY_W-1:0]       wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [ENTRY_W-1:0]       rd_data_a,
	output logic [ENTRY_W-1:0]       rd_data_b
);

	logic [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

[rtl/core/pwl_ctrl.sv]
// pwl_ctrl: command sequencer, entry count and wake scan over the entry memory
// instantiates pwl_mem; uses pwl_pkg types
module pwl_ctrl import pwl_pkg::*; #(
	parameter int MAX_PROCESSES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	output logic              in_rdy,
	input  cmd_t              cmd,
	input  logic [ID_W-1:0]   waiter_id,
	input  logic [ID_W-1:0]   target_id,
	input  logic [CODE_W-1:0] exit_code,
	input  logic              out_free,
	output push_t             out_push
);

	localparam int IDX_W = $clog2(MAX_PROCESSES);
	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
	localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_PROCESSES);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, idx_q, cnt_m1;
	logic [ID_W-1:0]   target_q, pend_id_q;
	logic [CODE_W-1:0] code_q;
	logic              pend_vld_q;

	logic               wr_en, rd_en, accept, scan_end, match, take_match;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_data, rd_a, rd_b;

	assign cnt_m1     = cnt_q - CNT_W'(1);
	assign accept     = in_vld && in_rdy;
	assign scan_end   = idx_q >= cnt_q;
	assign match      = rd_a[ID_W-1:0] == target_q;
	assign take_match = !pend_vld_q || out_free;

	pwl_mem #(.DEPTH(MAX_PROCESSES)) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (idx_q[IDX_W-1:0]),
		.rd_addr_b (cnt_m1[IDX_W-1:0]),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_WAKE) state_d = ST_READ;
			end
			ST_READ: begin
				if (!scan_end) state_d = ST_CHECK;
				else if (out_free) state_d = ST_IDLE;
			end
			ST_CHECK: begin
				if (!match || take_match) state_d = ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_rdy   = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = cnt_q[IDX_W-1:0];
		wr_data  = {waiter_id, target_id};
		out_push = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_rdy = out_free;
				if (accept && cmd == CMD_WAIT) begin
					out_push.push     = 1'b1;
					out_push.res.last = 1'b1;
					if (cnt_q >= CAP) begin
						out_push.res.status = STAT_FULL;
					end else begin
						out_push.res.status = STAT_REGISTERED;
						wr_en               = 1'b1;
					end
				end
			end
			ST_READ: begin
				if (!scan_end) begin
					rd_en = 1'b1;
				end else if (out_free) begin
					// final beat of the wake: held waiter, or nobody found
					out_push.push     = 1'b1;
					out_push.res.last = 1'b1;
					if (pend_vld_q) begin
						out_push.res.status   = STAT_WOKEN;
						out_push.res.woken_id = pend_id_q;
						out_push.res.code_out = code_q;
					end else begin
						out_push.res.status = STAT_NONE;
					end
				end
			end
			ST_CHECK: begin
				if (match && take_match) begin
					// move the tail entry into the hole, recheck the same slot
					wr_en   = 1'b1;
					wr_addr = idx_q[IDX_W-1:0];
					wr_data = rd_b;
					if (pend_vld_q) begin
						out_push.push         = 1'b1;
						out_push.res.status   = STAT_WOKEN;
						out_push.res.woken_id = pend_id_q;
						out_push.res.code_out = code_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && cmd == CMD_WAIT && cnt_q < CAP) cnt_q <= cnt_q + CNT_W'(1);
					idx_q      <= '0;
					pend_vld_q <= 1'b0;
				end
				ST_READ: begin
					if (scan_end && out_free) pend_vld_q <= 1'b0;
				end
				ST_CHECK: begin
					if (!match) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (take_match) begin
						cnt_q      <= cnt_m1;
						pend_vld_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= target_id;
			code_q   <= exit_code;
		end
		if (state_q == ST_CHECK && match && take_match) pend_id_q <= rd_a[ENTRY_W-1:ID_W];
	end

endmodule

[rtl/core/process_wait_list_top.sv]
// process_wait_list_top: table of waiting processes, woken by the process they wait on
// instantiates pwl_ctrl (with pwl_mem) and holds the output register; uses pwl_pkg
//
// usage:
//   s_* channel takes one command beat: s_tuser = command (0 wait, 1 wake),
//   s_tdata = {exit_code, target_id, waiter_id}. m_* channel gives result beats:
//   m_tuser = status, m_tdata = {code_out, woken_id}, m_tlast = final beat of the command.
//   a wait appends (waiter, target) and answers one beat in the cycle after the accept,
//   or a table full status when MAX_PROCESSES entries are held; waits can be taken
//   one per cycle while the receiver keeps up.
//   a wake scans the entry memory from entry 0; each visited slot is first read from
//   memory, then compared; a match rewrites the slot from the tail entry and
//   the slot is checked again. one woken waiter is held back until the next match
//   or the scan end, so the last beat can carry m_tlast; with no match the wake gives
//   one none-waiting beat. s_tready is high only between commands and while the output
//   register is free. when the receiver stalls, the scan runs on until it has a beat
//   to give, then waits with the result in the output register; nothing is lost.
//   reset empties the table (count to zero); entry contents are not cleared and no
//   clearing pass is needed.
module process_wait_list_top import pwl_pkg::*; #(
	parameter int MAX_PROCESSES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // waiter_id[5:0], target_id[11:6], exit_code[43:12], zero
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // woken_id[5:0], code_out[37:6], zero
	output logic [1:0]  m_tuser,   // status
	output logic        m_tlast
);

	push_t   push;
	result_t res_q;
	logic    vld_q, out_free;

	assign out_free = !vld_q || m_tready;

	pwl_ctrl #(.MAX_PROCESSES(MAX_PROCESSES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (s_tvalid),
		.in_rdy    (s_tready),
		.cmd       (cmd_t'(s_tuser)),
		.waiter_id (s_tdata[5:0]),
		.target_id (s_tdata[11:6]),
		.exit_code (s_tdata[43:12]),
		.out_free  (out_free),
		.out_push  (push)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			if (push.push) vld_q <= 1'b1;
			else if (m_tready) vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) res_q <= push.res;
	end

	assign m_tvalid = vld_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {2'b00, res_q.code_out, res_q.woken_id};
	assign m_tlast  = res_q.last;

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for process_wait_list_top, wait/wake commands against a shadow table
// depends on pwl_pkg (status and command codes, result_t) and the rtl under rtl/core
// directed, table-full and backpressure tests, then random traffic under three idle mixes
module tb_top import pwl_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY  = 64;
	localparam int LIMIT     = 600000;
	localparam int STALL_LEN = 400;
	localparam int DRAIN     = 40;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// shadow copy of the wait table
	logic [ENTRY_W-1:0] shadow_tbl [CAPACITY];
	int                 shadow_cnt = 0;
	result_t            due_beats [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_ask     = 0;
	int stall_seen    = 0;
	int stall_left    = 0;
	int cycle_cnt     = 0;
	int errors        = 0;
	int n_cmds        = 0;
	int n_beats       = 0;
	int n_multi       = 0;
	int n_full        = 0;
	result_t want;

	process_wait_list_top #(.MAX_PROCESSES(CAPACITY)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4ns clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still due", cycle_cnt, due_beats.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (stall_ask != stall_seen) begin
			stall_seen = stall_ask;
			stall_left = STALL_LEN;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_beats++;
			if (due_beats.size() == 0) begin
				$display("%0t: unexpected beat status %0d id %0d code %h last %0b", $time,
					m_tuser, m_tdata[5:0], m_tdata[37:6], m_tlast);
				errors++;
			end else begin
				want = due_beats.pop_front();
				if (m_tuser != want.status) begin
					$display("%0t: status expected %0d, got %0d", $time, want.status, m_tuser);
					errors++;
				end
				if (m_tdata[5:0] != want.woken_id) begin
					$display("%0t: woken_id expected %0d, got %0d", $time, want.woken_id,
						m_tdata[5:0]);
					errors++;
				end
				if (m_tdata[37:6] != want.code_out) begin
					$display("%0t: code_out expected %h, got %h", $time, want.code_out,
						m_tdata[37:6]);
					errors++;
				end
				if (m_tlast != want.last) begin
					$display("%0t: last expected %0b, got %0b", $time, want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	function automatic result_t make_beat(input status_t st, input logic [ID_W-1:0] id,
			input logic [CODE_W-1:0] code, input logic fin);
		result_t r;
		r.status   = st;
		r.woken_id = id;
		r.code_out = code;
		r.last     = fin;
		return r;
	endfunction

	// update the shadow table and queue the beats this command must produce
	task automatic apply_to_table(input cmd_t cmd, input logic [ID_W-1:0] waiter,
			input logic [ID_W-1:0] target, input logic [CODE_W-1:0] code);
		int      idx;
		int      hits;
		result_t held;
		n_cmds++;
		if (cmd == CMD_WAIT) begin
			if (shadow_cnt >= CAPACITY) begin
				due_beats.push_back(make_beat(STAT_FULL, '0, '0, 1'b1));
				n_full++;
			end else begin
				shadow_tbl[shadow_cnt] = {waiter, target};
				shadow_cnt++;
				due_beats.push_back(make_beat(STAT_REGISTERED, '0, '0, 1'b1));
			end
		end else begin
			idx  = 0;
			hits = 0;
			while (idx < shadow_cnt) begin
				if (shadow_tbl[idx][ID_W-1:0] == target) begin
					if (hits > 0)
						due_beats.push_back(held);
					held = make_beat(STAT_WOKEN, shadow_tbl[idx][ENTRY_W-1:ID_W], code, 1'b0);
					hits++;
					// tail entry moves into the hole and is checked at the same slot
					shadow_tbl[idx] = shadow_tbl[shadow_cnt-1];
					shadow_cnt--;
				end else begin
					idx++;
				end
			end
			if (hits == 0) begin
				due_beats.push_back(make_beat(STAT_NONE, '0, '0, 1'b1));
			end else begin
				held.last = 1'b1;
				due_beats.push_back(held);
				if (hits > 1)
					n_multi++;
			end
		end
	endtask

	task automatic issue_cmd(input cmd_t cmd, input logic [ID_W-1:0] waiter,
			input logic [ID_W-1:0] target, input logic [CODE_W-1:0] code);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, code, target, waiter};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_to_table(cmd, waiter, target, code);
	endtask

	task automatic go_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_basic();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		issue_cmd(CMD_WAKE, 6'd0, 6'd0, 32'h1234_5678);     // empty table
		issue_cmd(CMD_WAIT, 6'd0, 6'd0, 32'hFFFF_FFFF);     // code ignored on wait
		issue_cmd(CMD_WAIT, 6'd63, 6'd63, 32'h0);
		issue_cmd(CMD_WAIT, 6'd5, 6'd0, 32'h0);
		issue_cmd(CMD_WAIT, 6'd17, 6'd42, 32'h0);
		issue_cmd(CMD_WAIT, 6'd63, 6'd0, 32'h0);
		issue_cmd(CMD_WAKE, 6'd63, 6'd63, 32'hFFFF_FFFF);   // waiter ignored on wake
		issue_cmd(CMD_WAKE, 6'd0, 6'd0, 32'h0);             // three matches
		issue_cmd(CMD_WAKE, 6'd0, 6'd0, 32'h0);             // nothing left
		issue_cmd(CMD_WAKE, 6'd21, 6'd42, 32'hA5A5_5A5A);
		// tail entries that match again after being moved into the hole
		issue_cmd(CMD_WAIT, 6'd1, 6'd7, 32'h0);
		issue_cmd(CMD_WAIT, 6'd2, 6'd9, 32'h0);
		issue_cmd(CMD_WAIT, 6'd3, 6'd7, 32'h0);
		issue_cmd(CMD_WAIT, 6'd4, 6'd7, 32'h0);
		issue_cmd(CMD_WAKE, 6'd0, 6'd7, 32'h8000_0001);
		issue_cmd(CMD_WAKE, 6'd0, 6'd9, 32'h7FFF_FFFE);
		go_quiet();
	endtask

	task automatic test_full_table();
		logic [ID_W-1:0] ta;
		logic [ID_W-1:0] tc;
		send_idle_pct = 10;
		recv_idle_pct = 10;
		ta = ID_W'($urandom_range(63));
		tc = ta ^ 6'h2a;
		// all entries on one process: one wake releases the whole table
		for (int k = 0; k < CAPACITY; k++)
			issue_cmd(CMD_WAIT, ID_W'($urandom), ta, $urandom);
		issue_cmd(CMD_WAIT, ID_W'($urandom), ta, $urandom);     // full
		issue_cmd(CMD_WAKE, ID_W'($urandom), tc, $urandom);     // full scan, no hit
		issue_cmd(CMD_WAKE, ID_W'($urandom), ta, $urandom);
		go_quiet();
	endtask

	task automatic test_backpressure();
		logic [ID_W-1:0] t;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		t = ID_W'($urandom_range(63));
		stall_ask++;
		for (int k = 0; k < 8; k++)
			issue_cmd(CMD_WAIT, ID_W'($urandom), $urandom_range(2) != 0 ? t : ~t, $urandom);
		issue_cmd(CMD_WAKE, ID_W'($urandom), t, $urandom);
		issue_cmd(CMD_WAKE, ID_W'($urandom), ~t, $urandom);
		for (int k = 0; k < 4; k++)
			issue_cmd(CMD_WAIT, ID_W'($urandom), t, $urandom);
		go_quiet();
	endtask

	task automatic test_random(input int count, input int send_pct, input int recv_pct);
		logic [ID_W-1:0] pool [4];
		logic [ID_W-1:0] target;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int k = 0; k < 4; k++)
			pool[k] = ID_W'($urandom_range(63));
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 60) begin
				target = ($urandom_range(99) < 80) ? pool[$urandom_range(3)]
					: ID_W'($urandom_range(63));
				issue_cmd(CMD_WAIT, ID_W'($urandom), target, $urandom);
			end else begin
				target = ($urandom_range(99) < 75) ? pool[$urandom_range(3)]
					: ID_W'($urandom_range(63));
				issue_cmd(CMD_WAKE, ID_W'($urandom), target, $urandom);
			end
		end
		go_quiet();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic();
		test_full_table();
		test_backpressure();
		test_random(11, 32, 71);
		test_random(11, 71, 32);
		test_random(11, 0, 0);
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("covered %0d commands and %0d result beats: %0d multi-waiter wakes,",
			n_cmds, n_beats, n_multi);
		$display("%0d full-table waits, a %0d-cycle receiver hold-off and %0d mismatches",
			n_full, STALL_LEN, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
